// ===== src/rwlt_pkg.sv =====
// ----------------------------------------------------------------------------
// rwlt_pkg: shared types and constants for the reader-writer lock table
// Action and status codes, request/result payloads, queue sizing.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package rwlt_pkg;

  localparam int unsigned DEF_NUM_LOCKS   = 256;
  localparam int unsigned DEF_MAX_HOLDERS = 63;

  // Request queue between front and back; must be a power of two.
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);

  typedef enum logic [2:0] {
    ACT_READ      = 3'd0,
    ACT_WRITE     = 3'd1,
    ACT_UPGRADE   = 3'd2,
    ACT_REL_READ  = 3'd3,
    ACT_REL_WRITE = 3'd4
  } act_t;

  typedef enum logic [1:0] {
    ST_GRANTED  = 2'd0,
    ST_QUEUED   = 2'd1,
    ST_RELEASED = 2'd2,
    ST_ERROR    = 2'd3
  } status_t;

  typedef enum logic {
    BK_IDLE = 1'b0,
    BK_LOOK = 1'b1
  } back_state_t;

  typedef struct packed {
    logic [2:0] action;
    logic [7:0] lock_index;
  } in_req_t;

  typedef struct packed {
    status_t    status;
    logic [7:0] entry_index;
    logic [5:0] readers_woken;
    logic       writer_woken;
  } out_rsp_t;

  // Classified request as it travels through the queue.
  typedef struct packed {
    logic       bad;
    act_t       act;
    logic [7:0] lock_index;
  } cls_req_t;

endpackage

`default_nettype wire

// ===== src/rwlt_front.sv =====
// ----------------------------------------------------------------------------
// rwlt_front: request intake and classification
// Accepts requests, flags unknown actions and out-of-range entries.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module rwlt_front #(
  parameter int unsigned NUM_LOCKS = 256
) (
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  rwlt_pkg::in_req_t       in_data,
  input  wire logic               q_full,
  output logic                    q_push,
  output rwlt_pkg::cls_req_t      q_item
);
  import rwlt_pkg::*;

  logic in_range;
  logic act_known;

  assign in_range  = 17'(in_data.lock_index) < 17'(NUM_LOCKS);
  assign act_known = in_data.action <= ACT_REL_WRITE;

  assign in_stall = q_full;
  assign q_push   = in_valid && !q_full;

  always_comb begin
    q_item.bad        = !(in_range && act_known);
    q_item.act        = act_t'(in_data.action);
    q_item.lock_index = in_data.lock_index;
  end

endmodule

`default_nettype wire

// ===== src/rwlt_queue.sv =====
// ----------------------------------------------------------------------------
// rwlt_queue: short request queue between front and back
// Small FIFO of classified requests so each side stalls on its own.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module rwlt_queue (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               push,
  input  rwlt_pkg::cls_req_t      push_item,
  output logic                    full,
  input  wire logic               pop,
  output rwlt_pkg::cls_req_t      pop_item,
  output logic                    not_empty
);
  import rwlt_pkg::*;

  cls_req_t            slot_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [QPTR_W:0]     count_r, count_nxt;

  assign full      = count_r == (QPTR_W+1)'(QUEUE_DEPTH);
  assign not_empty = count_r != '0;
  assign pop_item  = slot_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop  ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r + (QPTR_W+1)'(push) - (QPTR_W+1)'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_item;
    end
  end

`ifndef SYNTHESIS
  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    full |-> !push) else $error("queue push while full");
  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !not_empty |-> !pop) else $error("queue pop while empty");
  a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
    (push && !pop) |=> count_r == $past(count_r) + 1'b1)
    else $error("queue count did not track push");
`endif

endmodule

`default_nettype wire

// ===== src/rwlt_back.sv =====
// ----------------------------------------------------------------------------
// rwlt_back: lock table and request execution
// Reads one entry, applies the lock action, writes it back, emits the result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module rwlt_back #(
  parameter int unsigned NUM_LOCKS   = 256,
  parameter int unsigned MAX_HOLDERS = 63
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               q_valid,
  input  rwlt_pkg::cls_req_t      q_item,
  output logic                    q_pop,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output rwlt_pkg::out_rsp_t      out_data
);
  import rwlt_pkg::*;

  // Only 256 entries are addressable through the 8-bit index.
  localparam int unsigned TBL_DEPTH = (NUM_LOCKS < 256) ? NUM_LOCKS : 256;
  localparam int unsigned AW        = (TBL_DEPTH > 1) ? $clog2(TBL_DEPTH) : 1;
  localparam int unsigned CW        = $clog2(MAX_HOLDERS + 1);
  localparam int unsigned ENT_W     = 1 + 3 * CW;
  localparam logic [CW-1:0] MAXV    = CW'(MAX_HOLDERS);

  // Entry layout: {writer_held, reader_count, waiting_writers, waiting_readers}
  logic [ENT_W-1:0]  mem [TBL_DEPTH];
  logic [TBL_DEPTH-1:0] vld_r;
  logic [ENT_W-1:0]  rd_r;
  logic              vld_rd_r;
  cls_req_t          item_r;

  back_state_t       state_r, state_nxt;
  logic              out_valid_r, out_valid_nxt;
  out_rsp_t          out_rsp_r;

  logic              slot_free;
  logic              rd_en, done, wr_en;
  logic [AW-1:0]     rd_addr, wr_addr;

  logic [ENT_W-1:0]  ent;
  logic              wh;
  logic [CW-1:0]     rc, ww, wr;
  logic              n_wh;
  logic [CW-1:0]     n_rc, n_ww, n_wr;
  logic [CW-1:0]     rc_eff, room, n_grant;
  logic              up_ok;
  status_t           st;
  logic              w_woken;

  assign slot_free = !out_valid_r || !out_stall;
  assign rd_addr   = AW'(q_item.lock_index);
  assign wr_addr   = AW'(item_r.lock_index);

  // ---- state machine ----
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      BK_IDLE: if (q_valid) state_nxt = BK_LOOK;
      BK_LOOK: if (slot_free) state_nxt = BK_IDLE;
      default: state_nxt = BK_IDLE;
    endcase
  end

  always_comb begin
    rd_en = 1'b0;
    done  = 1'b0;
    unique case (state_r)
      BK_IDLE: rd_en = q_valid;
      BK_LOOK: done  = slot_free;
      default: ;
    endcase
  end

  assign q_pop = rd_en;
  assign wr_en = done && !item_r.bad;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= BK_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // ---- table storage ----
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_r <= mem[rd_addr];
    end
    if (wr_en) begin
      mem[wr_addr] <= {n_wh, n_rc, n_ww, n_wr};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (wr_en) begin
      vld_r[wr_addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      vld_rd_r <= vld_r[rd_addr];
      item_r   <= q_item;
    end
  end

  // ---- lock action ----
  assign ent  = vld_rd_r ? rd_r : '0;
  assign wh   = ent[ENT_W-1];
  assign rc   = ent[3*CW-1:2*CW];
  assign ww   = ent[2*CW-1:CW];
  assign wr   = ent[CW-1:0];
  assign rc_eff  = (item_r.act == ACT_UPGRADE) ? rc - 1'b1 : rc;
  assign up_ok   = (item_r.act == ACT_WRITE) || (rc != '0);
  assign room    = MAXV - rc;
  assign n_grant = (wr < room) ? wr : room;

  always_comb begin
    n_wh    = wh;
    n_rc    = rc;
    n_ww    = ww;
    n_wr    = wr;
    st      = ST_ERROR;
    w_woken = 1'b0;
    if (!item_r.bad) begin
      unique case (item_r.act)
        ACT_READ: begin
          if (wh || ww != '0) begin
            if (wr < MAXV) begin
              n_wr = wr + 1'b1;
              st   = ST_QUEUED;
            end
          end else if (rc < MAXV) begin
            n_rc = rc + 1'b1;
            st   = ST_GRANTED;
          end
        end
        ACT_WRITE, ACT_UPGRADE: begin
          if (up_ok) begin
            if (wh || rc_eff != '0) begin
              if (ww < MAXV) begin
                n_ww = ww + 1'b1;
                n_rc = rc_eff;
                st   = ST_QUEUED;
              end
            end else begin
              n_wh = 1'b1;
              n_rc = rc_eff;
              st   = ST_GRANTED;
            end
          end
        end
        ACT_REL_READ: begin
          if (rc != '0) begin
            n_rc = rc - 1'b1;
            // last reader out hands the lock to a waiting writer
            if (rc == CW'(1) && !wh && ww != '0) begin
              n_ww    = ww - 1'b1;
              n_wh    = 1'b1;
              w_woken = 1'b1;
            end
            st = ST_RELEASED;
          end
        end
        ACT_REL_WRITE: begin
          if (wh) begin
            n_wh = 1'b0;
            if (ww != '0 && rc == '0) begin
              n_ww    = ww - 1'b1;
              n_wh    = 1'b1;
              w_woken = 1'b1;
            end else if (ww == '0) begin
              n_rc = rc + n_grant;
              n_wr = wr - n_grant;
            end
            st = ST_RELEASED;
          end
        end
        default: ;
      endcase
    end
  end

  // ---- result register ----
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (done) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (done) begin
      out_rsp_r.status        <= st;
      out_rsp_r.entry_index   <= item_r.lock_index;
      out_rsp_r.readers_woken <= (!item_r.bad && item_r.act == ACT_REL_WRITE && wh &&
                                  ww == '0) ? 6'(n_grant) : 6'd0;
      out_rsp_r.writer_woken  <= w_woken;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_rsp_r;

`ifndef SYNTHESIS
  a_pop_idle: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> state_r == BK_IDLE) else $error("pop outside idle");
  a_hold_look: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == BK_LOOK && !slot_free) |=> state_r == BK_LOOK)
    else $error("left lookup with result slot busy");
  a_result_out: assert property (@(posedge clk) disable iff (!rst_n)
    done |=> out_valid_r) else $error("finished request gave no result");
  a_err_no_write: assert property (@(posedge clk) disable iff (!rst_n)
    (done && item_r.bad) |-> (!wr_en && st == ST_ERROR))
    else $error("bad request touched the table");
`endif

endmodule

`default_nettype wire

// ===== src/reader_writer_lock_table.sv =====
// A request accepted into an empty block goes through the queue slot, the table
//   read and request registers and then the result register. The back end reads
//   the entry in BK_IDLE, then updates it and loads the result register in BK_LOOK.
// Up to QUEUE_DEPTH requests wait between front and back, so input is taken while
//   a result is stalled. Reset (rst_n low, synchronous) clears all entry valid
//   bits at once; every entry then reads as unlocked. No clearing pass.
// ----------------------------------------------------------------------------
// reader_writer_lock_table: reader-writer lock table, writer preference
// Front classifies requests, a short queue decouples it from the back end,
// which holds the lock table and performs grants, queuing and hand-offs.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module reader_writer_lock_table #(
  parameter int unsigned NUM_LOCKS   = rwlt_pkg::DEF_NUM_LOCKS,
  parameter int unsigned MAX_HOLDERS = rwlt_pkg::DEF_MAX_HOLDERS
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  // request channel
  input  wire logic             in_valid,
  output logic                  in_stall,
  input  rwlt_pkg::in_req_t     in_data,
  // result channel
  output logic                  out_valid,
  input  wire logic             out_stall,
  output rwlt_pkg::out_rsp_t    out_data
);
  import rwlt_pkg::*;

  // front -> queue
  logic      q_push;
  cls_req_t  q_push_item;
  logic      q_full;
  // queue -> back
  logic      q_pop;
  cls_req_t  q_pop_item;
  logic      q_not_empty;

  // Front: takes a request whenever the queue has room; marks unknown
  // actions and entries past NUM_LOCKS so the back end answers them as errors.
  rwlt_front #(
    .NUM_LOCKS (NUM_LOCKS)
  ) u_front (
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_item   (q_push_item)
  );

  // Queue: keeps the front moving while the back end waits on a stalled result.
  rwlt_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_item (q_push_item),
    .full      (q_full),
    .pop       (q_pop),
    .pop_item  (q_pop_item),
    .not_empty (q_not_empty)
  );

  // Back: one read-modify-write of the addressed entry per request. Only one
  // request is in flight, so the write lands before the next read.
  rwlt_back #(
    .NUM_LOCKS   (NUM_LOCKS),
    .MAX_HOLDERS (MAX_HOLDERS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_not_empty),
    .q_item    (q_pop_item),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire

// ===== tb/sv/reader_writer_lock_table_tb.sv =====
// ----------------------------------------------------------------------------
// reader_writer_lock_table_tb: self-checking bench for the lock table
// Drives lock requests through a short directed script and then random
// traffic on a few busy entries plus flood episodes that overflow counters.
// Results are checked field by field against an in-bench lock table model.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module reader_writer_lock_table_tb;
  import rwlt_pkg::*;

  localparam int unsigned ENTRIES         = DEF_NUM_LOCKS;
  localparam int unsigned HOLD_MAX        = DEF_MAX_HOLDERS;
  localparam int unsigned RANDOM_REQUESTS = 1300;
  // past this many requests both sides run flat out
  localparam int unsigned QUIET_AFTER     = 1150;
  localparam int unsigned WATCHDOG_LIMIT  = 4000;
  localparam int unsigned TAIL_CYCLES     = 10;
  localparam int unsigned SCRIPT_LEN      = 25;

  // action codes the block does not define
  localparam logic [2:0] ACT_UNDEF_FIRST = 3'd5;
  localparam logic [2:0] ACT_UNDEF_MID   = 3'd6;
  localparam logic [2:0] ACT_UNDEF_LAST  = 3'd7;

  // one row of the directed script; typed rows carry their own answer
  typedef struct packed {
    logic [2:0] act;
    logic [7:0] idx;
    logic       typed;
    status_t    st;
    logic [5:0] rw;
    logic       ww;
  } script_row_t;

  logic     clk = 1'b0;
  logic     rst_n;
  logic     in_valid;
  logic     in_stall;
  in_req_t  in_data;
  logic     out_valid;
  logic     out_stall = 1'b0;
  out_rsp_t out_data;

  // lock table as the bench sees it
  bit          writer_holds [ENTRIES];
  int unsigned readers_in   [ENTRIES];
  int unsigned writers_wait [ENTRIES];
  int unsigned readers_wait [ENTRIES];

  out_rsp_t    outcomes_due [$];
  out_rsp_t    due_rsp;
  int unsigned requests_sent = 0;
  int unsigned mismatches    = 0;
  int unsigned quiet_cycles  = 0;
  int unsigned stall_left    = 0;
  bit          idle_on       = 1'b0;

  reader_writer_lock_table u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  always #1 clk = ~clk;

  // --------------------------------------------------------------------------
  // Lock table model. Applies one request to the bench's copy of the table
  // and returns the result the block must give for it. Every 8-bit index is
  // a valid entry at the default table size, so no range check is needed.
  // --------------------------------------------------------------------------
  function automatic out_rsp_t arbitrate_lock(input in_req_t req);
    out_rsp_t    rsp;
    int unsigned e;
    int unsigned rc;
    int unsigned ww;
    int unsigned wr;
    int unsigned room;
    int unsigned n;
    bit          wh;
    rsp.status        = ST_ERROR;
    rsp.entry_index   = req.lock_index;
    rsp.readers_woken = '0;
    rsp.writer_woken  = 1'b0;
    e  = 32'(req.lock_index);
    wh = writer_holds[e];
    rc = readers_in[e];
    ww = writers_wait[e];
    wr = readers_wait[e];
    case (req.action)
      ACT_READ: begin
        // writer preference: a waiting writer blocks new readers
        if (wh || ww > 0) begin
          if (wr < HOLD_MAX) begin
            readers_wait[e] = wr + 1;
            rsp.status = ST_QUEUED;
          end
        end else if (rc < HOLD_MAX) begin
          readers_in[e] = rc + 1;
          rsp.status = ST_GRANTED;
        end
      end
      ACT_WRITE, ACT_UPGRADE: begin
        // an upgrade first gives up the caller's own read hold
        if (req.action != ACT_UPGRADE || rc > 0) begin
          if (req.action == ACT_UPGRADE) rc = rc - 1;
          if (wh || rc > 0) begin
            if (ww < HOLD_MAX) begin
              writers_wait[e] = ww + 1;
              readers_in[e] = rc;
              rsp.status = ST_QUEUED;
            end
          end else begin
            writer_holds[e] = 1'b1;
            readers_in[e] = rc;
            rsp.status = ST_GRANTED;
          end
        end
      end
      ACT_REL_READ: begin
        if (rc > 0) begin
          rc = rc - 1;
          readers_in[e] = rc;
          // last reader out hands over to one waiting writer
          if (rc == 0 && !wh && ww > 0) begin
            writers_wait[e] = ww - 1;
            writer_holds[e] = 1'b1;
            rsp.writer_woken = 1'b1;
          end
          rsp.status = ST_RELEASED;
        end
      end
      ACT_REL_WRITE: begin
        if (wh) begin
          writer_holds[e] = 1'b0;
          if (ww > 0 && rc == 0) begin
            writers_wait[e] = ww - 1;
            writer_holds[e] = 1'b1;
            rsp.writer_woken = 1'b1;
          end else if (ww == 0) begin
            // all waiting readers go, as many as fit under the holder cap
            room = (rc < HOLD_MAX) ? HOLD_MAX - rc : 0;
            n = (wr < room) ? wr : room;
            readers_in[e] = rc + n;
            readers_wait[e] = wr - n;
            rsp.readers_woken = n[5:0];
          end
          rsp.status = ST_RELEASED;
        end
      end
      default: ;  // undefined action: error, table untouched
    endcase
    return rsp;
  endfunction

  // --------------------------------------------------------------------------
  // Request side. The expected result is queued before the request goes out;
  // it cannot come back before the request is taken.
  // --------------------------------------------------------------------------
  task automatic post_request(input in_req_t req, input out_rsp_t due);
    int unsigned gap;
    if (idle_on && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 9);
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    outcomes_due.push_back(due);
    @(negedge clk);
    in_valid <= 1'b1;
    in_data  <= req;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    requests_sent++;
  endtask

  task automatic issue_request(input logic [2:0] act, input logic [7:0] idx);
    in_req_t req;
    req.action     = act;
    req.lock_index = idx;
    post_request(req, arbitrate_lock(req));
  endtask

  // Mostly well-formed traffic: releases that would fail are usually steered
  // to the release that matches what the entry holds.
  function automatic logic [2:0] choose_action(input logic [7:0] idx);
    int unsigned r;
    logic [2:0]  act;
    r = $urandom_range(0, 99);
    if (r < 4)       return ACT_UNDEF_FIRST + 3'($urandom_range(0, 2));
    else if (r < 32) act = ACT_READ;
    else if (r < 46) act = ACT_WRITE;
    else if (r < 56) act = ACT_UPGRADE;
    else if (r < 78) act = ACT_REL_READ;
    else             act = ACT_REL_WRITE;
    if ($urandom_range(0, 4) != 0) begin
      if (act == ACT_REL_READ && readers_in[idx] == 0 && writer_holds[idx])
        act = ACT_REL_WRITE;
      else if (act == ACT_REL_WRITE && !writer_holds[idx] && readers_in[idx] != 0)
        act = ACT_REL_READ;
      else if (act == ACT_UPGRADE && readers_in[idx] == 0)
        act = ACT_READ;
    end
    return act;
  endfunction

  // release whatever is held until the entry is free
  task automatic drain_entry(input logic [7:0] e);
    for (int k = 0; k < 400 && (writer_holds[e] || readers_in[e] != 0); k++)
      issue_request(writer_holds[e] ? ACT_REL_WRITE : ACT_REL_READ, e);
  endtask

  // Pile readers and writers onto one entry until the counters saturate,
  // then hand the lock down the line. With a writer in front the readers
  // all queue and are woken together on a write release with no writer waiting.
  task automatic flood_entry(input logic [7:0] e);
    int unsigned n_rd;
    int unsigned n_wr;
    n_rd = $urandom_range(0, 1) ? $urandom_range(60, 66) : $urandom_range(1, 20);
    n_wr = ($urandom_range(0, 3) == 0) ? $urandom_range(55, 66) : $urandom_range(0, 6);
    drain_entry(e);
    if ($urandom_range(0, 1)) issue_request(ACT_WRITE, e);
    repeat (n_rd) issue_request(ACT_READ, e);
    repeat (n_wr) issue_request(ACT_WRITE, e);
    drain_entry(e);
  endtask

  // --------------------------------------------------------------------------
  // Result side: random stall bursts while idling is on.
  // --------------------------------------------------------------------------
  always @(negedge clk) begin
    if (stall_left != 0) begin
      out_stall <= 1'b1;
      stall_left = stall_left - 1;
    end else if (idle_on && $urandom_range(0, 5) == 0) begin
      out_stall <= 1'b1;
      stall_left = $urandom_range(0, 8);
    end else begin
      out_stall <= 1'b0;
    end
  end

  task automatic check_field(input string name, input int unsigned want,
                             input int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, actual %0d", name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (outcomes_due.size() == 0) begin
        $error("result for entry %0d with no request outstanding", out_data.entry_index);
        mismatches++;
      end else begin
        due_rsp = outcomes_due.pop_front();
        check_field("status", due_rsp.status, out_data.status);
        check_field("entry_index", due_rsp.entry_index, out_data.entry_index);
        check_field("readers_woken", due_rsp.readers_woken, out_data.readers_woken);
        check_field("writer_woken", due_rsp.writer_woken, out_data.writer_woken);
      end
    end
  end

  // Watchdog: too long with neither channel moving ends the run.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("FAILURE");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin : stimulus
    script_row_t script [SCRIPT_LEN];
    logic [7:0]  hot [4];
    logic [7:0]  idx;
    in_req_t     req;
    out_rsp_t    due;
    int unsigned episode;

    rst_n    = 1'b0;
    in_valid = 1'b0;
    in_data  = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      writer_holds[i] = 1'b0;
      readers_in[i]   = 0;
      writers_wait[i] = 0;
      readers_wait[i] = 0;
    end

    // Directed part. Fresh table: bad releases and undefined actions are
    // errors; entry 0 walks reader -> queued writer -> queued reader -> hand-offs;
    // entry 255 has two readers woken at once and an upgrade that must wait.
    script = '{
      '{ACT_REL_READ,    8'h00, 1'b1, ST_ERROR,    6'd0, 1'b0},
      '{ACT_REL_WRITE,   8'hFF, 1'b1, ST_ERROR,    6'd0, 1'b0},
      '{ACT_UPGRADE,     8'h80, 1'b1, ST_ERROR,    6'd0, 1'b0},
      '{ACT_UNDEF_FIRST, 8'h00, 1'b1, ST_ERROR,    6'd0, 1'b0},
      '{ACT_UNDEF_LAST,  8'hFF, 1'b1, ST_ERROR,    6'd0, 1'b0},
      '{ACT_UNDEF_MID,   8'h55, 1'b1, ST_ERROR,    6'd0, 1'b0},
      '{ACT_READ,        8'h00, 1'b1, ST_GRANTED,  6'd0, 1'b0},
      '{ACT_WRITE,       8'h00, 1'b0, ST_GRANTED,  6'd0, 1'b0},
      '{ACT_READ,        8'h00, 1'b0, ST_GRANTED,  6'd0, 1'b0},
      '{ACT_REL_READ,    8'h00, 1'b0, ST_GRANTED,  6'd0, 1'b0},
      '{ACT_REL_WRITE,   8'h00, 1'b0, ST_GRANTED,  6'd0, 1'b0},
      '{ACT_REL_READ,    8'h00, 1'b0, ST_GRANTED,  6'd0, 1'b0},
      '{ACT_WRITE,       8'hFF, 1'b1, ST_GRANTED,  6'd0, 1'b0},
      '{ACT_READ,        8'hFF, 1'b0, ST_GRANTED,  6'd0, 1'b0},
      '{ACT_READ,        8'hFF, 1'b0, ST_GRANTED,  6'd0, 1'b0},
      '{ACT_REL_WRITE,   8'hFF, 1'b0, ST_GRANTED,  6'd0, 1'b0},
      '{ACT_UPGRADE,     8'hFF, 1'b0, ST_GRANTED,  6'd0, 1'b0},
      '{ACT_REL_READ,    8'hFF, 1'b0, ST_GRANTED,  6'd0, 1'b0},
      '{ACT_REL_WRITE,   8'hFF, 1'b0, ST_GRANTED,  6'd0, 1'b0},
      '{ACT_REL_READ,    8'hFF, 1'b0, ST_GRANTED,  6'd0, 1'b0},
      '{ACT_READ,        8'hAA, 1'b1, ST_GRANTED,  6'd0, 1'b0},
      '{ACT_UPGRADE,     8'hAA, 1'b0, ST_GRANTED,  6'd0, 1'b0},
      '{ACT_REL_WRITE,   8'hAA, 1'b0, ST_GRANTED,  6'd0, 1'b0},
      '{ACT_WRITE,       8'h55, 1'b1, ST_GRANTED,  6'd0, 1'b0},
      '{ACT_WRITE,       8'h55, 1'b0, ST_GRANTED,  6'd0, 1'b0}
    };

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    idle_on = 1'b1;

    foreach (script[i]) begin
      req.action     = script[i].act;
      req.lock_index = script[i].idx;
      // the model still runs on typed rows so its table stays in step
      due = arbitrate_lock(req);
      if (script[i].typed) begin
        due.status        = script[i].st;
        due.readers_woken = script[i].rw;
        due.writer_woken  = script[i].ww;
      end
      post_request(req, due);
    end

    // Random part: episodes of traffic on four busy entries, with an
    // occasional flood. Idling is switched per episode so some stretches
    // run without gaps, and is off for good near the end.
    foreach (hot[i]) hot[i] = 8'($urandom_range(0, 255));
    episode = 0;
    while (requests_sent < SCRIPT_LEN + RANDOM_REQUESTS) begin
      idle_on = (requests_sent < QUIET_AFTER) && ($urandom_range(0, 3) != 0);
      if (episode == 0 || $urandom_range(0, 7) == 0) begin
        flood_entry(8'($urandom_range(0, 255)));
      end else begin
        hot[$urandom_range(0, 3)] = 8'($urandom_range(0, 255));
        repeat (20) begin
          idx = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(0, 255))
                                            : hot[$urandom_range(0, 3)];
          issue_request(choose_action(idx), idx);
        end
      end
      episode++;
    end
    idle_on = 1'b0;

    @(negedge clk);
    in_valid <= 1'b0;
    while (outcomes_due.size() != 0) @(posedge clk);
    // catch any stray result after the last expected one
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
src/rwlt_pkg.sv
src/rwlt_front.sv
src/rwlt_queue.sv
src/rwlt_back.sv
src/reader_writer_lock_table.sv
tb/sv/reader_writer_lock_table_tb.sv
